// ===== design/assert_macros.svh =====
// Assertion helpers for the fresnel_dielectric_reflectance design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop on every rising clk edge outside reset.
`define FDR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that cond at one edge implies prop at the next edge.
`define FDR_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> prop) else $error(msg);

`endif

// ===== design/fdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdr_pkg
// Types and constants for the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int VEC_FRAC_BITS = 14;
	localparam int OUT_FRAC_BITS = 16;
	// Cosine is carried with 30 fraction bits.
	localparam int COS_SHIFT     = 30 - 2 * VEC_FRAC_BITS;
	localparam int SQRT_STEPS    = 32;
	localparam int DIV_STEPS     = 32;
	// Front stages, sqrt steps, two product stages, divide steps, square stage.
	localparam int NUM_STAGES    = 6 + SQRT_STEPS + 2 + DIV_STEPS + 1;

	localparam logic [16:0] ONE_OUT = 17'(1 << OUT_FRAC_BITS);

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [15:0]        index_incident;
		logic [15:0]        index_transmit;
	} fdr_in_t;

	typedef struct packed {
		logic [16:0] reflectance;
		logic [16:0] transmittance;
		logic        total_internal;
	} fdr_out_t;

endpackage

// ===== design/fresnel_dielectric_reflectance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance and transmittance at a dielectric interface.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, in_data) takes one ray hit per
// transfer: direction, normal and the two refractive indices. The output
// channel (out_valid, out_ready, out_data) returns one result per item, in
// order: reflectance, transmittance and the total internal reflection flag.
// Throughput is one item per cycle while the receiver does not stall. Each
// item passes through six front stages (dot product, cosine, squares, the
// cos2 squared term), 32 square-root steps one bit each, two product stages,
// 32 long-division steps one quotient bit each for both amplitude ratios,
// one squaring stage and the output register.
// All stages advance together. When the receiver stalls with a result held
// in the output register, the whole pipeline holds and in_ready drops; no
// item is lost or repeated. Reset clears the valid bits only, so the block
// is empty and ready right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fresnel_dielectric_reflectance (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fdr_pkg::fdr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output fdr_pkg::fdr_out_t out_data
);

	localparam int NST = fdr_pkg::NUM_STAGES;
	localparam int SQN = fdr_pkg::SQRT_STEPS;
	localparam int DVN = fdr_pkg::DIV_STEPS;

	logic               en;
	logic [NST-1:0]     vld_q;
	logic               out_valid_q;
	fdr_pkg::fdr_out_t  out_data_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[NST-2:0], in_valid};
			out_valid_q <= vld_q[NST-1];
		end
	end

	// Stage 1: component products and index squares.
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [15:0]        n1_s1;
	logic [31:0]        n1sq_s1, n2sq_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= $signed(in_data.dir_x) * $signed(in_data.norm_x);
			py_s1   <= $signed(in_data.dir_y) * $signed(in_data.norm_y);
			pz_s1   <= $signed(in_data.dir_z) * $signed(in_data.norm_z);
			n1_s1   <= in_data.index_incident;
			n1sq_s1 <= 32'(in_data.index_incident) * 32'(in_data.index_incident);
			n2sq_s1 <= 32'(in_data.index_transmit) * 32'(in_data.index_transmit);
		end
	end

	// Stage 2: dot product, magnitude saturated to one, rescaled to Q.30.
	logic signed [33:0] dot;
	logic [33:0]        dot_mag;
	logic [28:0]        cos_sat;
	logic [30:0]        c_s2;
	logic [15:0]        n1_s2;
	logic [31:0]        n1sq_s2, n2sq_s2;

	always_comb begin
		dot     = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		dot_mag = dot[33] ? 34'(-dot) : 34'(dot);
		cos_sat = (dot_mag > 34'(1 << (2 * fdr_pkg::VEC_FRAC_BITS)))
			? 29'(1 << (2 * fdr_pkg::VEC_FRAC_BITS)) : dot_mag[28:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= 31'(cos_sat) << fdr_pkg::COS_SHIFT;
			n1_s2   <= n1_s1;
			n1sq_s2 <= n1sq_s1;
			n2sq_s2 <= n2sq_s1;
		end
	end

	// Stage 3: cosine squared.
	logic [61:0] csq_s3;
	logic [30:0] c_s3;
	logic [15:0] n1_s3;
	logic [31:0] n1sq_s3, n2sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s3  <= 62'(c_s2) * 62'(c_s2);
			c_s3    <= c_s2;
			n1_s3   <= n1_s2;
			n1sq_s3 <= n1sq_s2;
			n2sq_s3 <= n2sq_s2;
		end
	end

	// Stage 4: sine squared, rounded half up to Q.30.
	logic [61:0] sin_full;
	logic [30:0] s_s4;
	logic [30:0] c_s4;
	logic [15:0] n1_s4;
	logic [31:0] n1sq_s4, n2sq_s4;

	assign sin_full = 62'(1) << 60;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4    <= 31'((sin_full - csq_s3 + (62'(1) << 29)) >> 30);
			c_s4    <= c_s3;
			n1_s4   <= n1_s3;
			n1sq_s4 <= n1sq_s3;
			n2sq_s4 <= n2sq_s3;
		end
	end

	// Stage 5: n1 squared times sine squared.
	logic [62:0] m_s5;
	logic [30:0] c_s5;
	logic [15:0] n1_s5;
	logic [31:0] n2sq_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= 63'(n1sq_s4) * 63'(s_s4);
			c_s5    <= c_s4;
			n1_s5   <= n1_s4;
			n2sq_s5 <= n2sq_s4;
		end
	end

	// Stage 6: W = n2^2 cos2^2 scaled; W at or below zero is total reflection.
	logic [63:0] w_diff;
	logic        w_tir;
	logic [61:0] w_s6;
	logic        tir_s6;
	logic [30:0] c_s6;
	logic [15:0] n1_s6;
	logic [31:0] n2sq_s6;

	always_comb begin
		w_diff = (64'(n2sq_s5) << 30) - 64'(m_s5);
		w_tir  = w_diff[63] || (w_diff == 64'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s6    <= w_tir ? 62'd0 : w_diff[61:0];
			tir_s6  <= w_tir;
			c_s6    <= c_s5;
			n1_s6   <= n1_s5;
			n2sq_s6 <= n2sq_s5;
		end
	end

	// Square root, one result bit per stage.
	logic [62:0] sqx_s  [SQN+1];
	logic [62:0] sqr_s  [SQN+1];
	logic        sqt_s  [SQN+1];
	logic [30:0] sqc_s  [SQN+1];
	logic [15:0] sqn1_s [SQN+1];
	logic [31:0] sqn2_s [SQN+1];

	assign sqx_s[0]  = 63'(w_s6);
	assign sqr_s[0]  = '0;
	assign sqt_s[0]  = tir_s6;
	assign sqc_s[0]  = c_s6;
	assign sqn1_s[0] = n1_s6;
	assign sqn2_s[0] = n2sq_s6;

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
		logic [62:0] trial;
		logic        take;

		always_comb begin
			trial = sqr_s[k] + BIT;
			take  = sqx_s[k] >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqx_s[k+1]  <= take ? sqx_s[k] - trial : sqx_s[k];
				sqr_s[k+1]  <= take ? (sqr_s[k] >> 1) + BIT : sqr_s[k] >> 1;
				sqt_s[k+1]  <= sqt_s[k];
				sqc_s[k+1]  <= sqc_s[k];
				sqn1_s[k+1] <= sqn1_s[k];
				sqn2_s[k+1] <= sqn2_s[k];
			end
		end
	end

	// Product stage: the four terms of the two amplitude ratios.
	logic [30:0] q;
	logic [62:0] apar_m1;
	logic [46:0] bpar_m1;
	logic [46:0] aper_m1;
	logic [30:0] q_m1;
	logic        tir_m1;

	assign q = sqr_s[SQN][30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			apar_m1 <= 63'(sqn2_s[SQN]) * 63'(sqc_s[SQN]);
			bpar_m1 <= 47'(sqn1_s[SQN]) * 47'(q);
			aper_m1 <= 47'(sqn1_s[SQN]) * 47'(sqc_s[SQN]);
			q_m1    <= q;
			tir_m1  <= sqt_s[SQN];
		end
	end

	// Numerators and denominators of both ratios.
	logic [63:0] pa, pb, ra, rb;
	logic [63:0] dpar_m2, npar_m2, dper_m2, nper_m2;
	logic        tir_m2;

	always_comb begin
		pa = 64'(apar_m1);
		pb = 64'(bpar_m1) << 15;
		ra = 64'(aper_m1);
		rb = 64'(q_m1) << 15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dpar_m2 <= pa + pb;
			npar_m2 <= (pa > pb) ? pa - pb : pb - pa;
			dper_m2 <= ra + rb;
			nper_m2 <= (ra > rb) ? ra - rb : rb - ra;
			tir_m2  <= tir_m1;
		end
	end

	// Long division of both ratios, one quotient bit per stage.
	logic [63:0] prem_s [DVN+1];
	logic [63:0] pden_s [DVN+1];
	logic [31:0] pquo_s [DVN+1];
	logic [63:0] rrem_s [DVN+1];
	logic [63:0] rden_s [DVN+1];
	logic [31:0] rquo_s [DVN+1];
	logic        dvt_s  [DVN+1];

	assign prem_s[0] = npar_m2;
	assign pden_s[0] = dpar_m2;
	assign pquo_s[0] = '0;
	assign rrem_s[0] = nper_m2;
	assign rden_s[0] = dper_m2;
	assign rquo_s[0] = '0;
	assign dvt_s[0]  = tir_m2;

	for (genvar j = 0; j < DVN; j++) begin : g_div
		logic [63:0] pr, rr;
		logic [31:0] pq, rq;
		logic        ptake, rtake;

		always_comb begin
			// The first step tests the integer bit without a shift.
			pr = (j == 0) ? prem_s[j] : prem_s[j] << 1;
			rr = (j == 0) ? rrem_s[j] : rrem_s[j] << 1;
			pq = (j == 0) ? pquo_s[j] : pquo_s[j] << 1;
			rq = (j == 0) ? rquo_s[j] : rquo_s[j] << 1;
			ptake = pr >= pden_s[j];
			rtake = rr >= rden_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prem_s[j+1] <= ptake ? pr - pden_s[j] : pr;
				pquo_s[j+1] <= ptake ? (pq | 32'd1) : pq;
				pden_s[j+1] <= pden_s[j];
				rrem_s[j+1] <= rtake ? rr - rden_s[j] : rr;
				rquo_s[j+1] <= rtake ? (rq | 32'd1) : rq;
				rden_s[j+1] <= rden_s[j];
				dvt_s[j+1]  <= dvt_s[j];
			end
		end
	end

	// Square both ratio magnitudes. A zero denominator means magnitude one.
	logic [31:0] rpar, rper;
	logic [63:0] psq_sq, rsq_sq;
	logic        tir_sq;

	always_comb begin
		rpar = (pden_s[DVN] == 64'd0) ? 32'h8000_0000 : pquo_s[DVN];
		rper = (rden_s[DVN] == 64'd0) ? 32'h8000_0000 : rquo_s[DVN];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psq_sq <= 64'(rpar) * 64'(rpar);
			rsq_sq <= 64'(rper) * 64'(rper);
			tir_sq <= dvt_s[DVN];
		end
	end

	// Average, round to the output format and saturate.
	logic [63:0] rsum;
	logic [16:0] refl;

	always_comb begin
		rsum = psq_sq + rsq_sq + (64'(1) << (62 - fdr_pkg::OUT_FRAC_BITS));
		refl = 17'(rsum >> (63 - fdr_pkg::OUT_FRAC_BITS));
		if (refl > fdr_pkg::ONE_OUT) begin
			refl = fdr_pkg::ONE_OUT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.total_internal <= tir_sq;
			out_data_q.reflectance    <= tir_sq ? fdr_pkg::ONE_OUT : refl;
			out_data_q.transmittance  <= tir_sq ? 17'd0 : fdr_pkg::ONE_OUT - refl;
		end
	end

	`FDR_ASSERT(a_tir_result, out_valid && out_data.total_internal |-> out_data.reflectance == fdr_pkg::ONE_OUT && out_data.transmittance == 17'd0, "total reflection result is not one and zero")
	`FDR_ASSERT(a_energy_sum, out_valid |-> (18'(out_data.reflectance) + 18'(out_data.transmittance)) == 18'(fdr_pkg::ONE_OUT), "reflectance and transmittance do not sum to one")
	`FDR_ASSERT_NEXT(a_stall_keeps, vld_q[NST-1] && !in_ready, vld_q[NST-1], "item in last stage lost during stall")

endmodule
